FILE: hw/rtl/rastrigin_fitness_accumulator_core_macros.svh
// assertion macros for the rastrigin fitness accumulator
`ifndef RASTRIGIN_FITNESS_ACCUMULATOR_CORE_MACROS_SVH
`define RASTRIGIN_FITNESS_ACCUMULATOR_CORE_MACROS_SVH

`ifndef ASSERT_OFF
`define RFA_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define RFA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define RFA_ASSERT_IMPLIES(lbl, ante, cons, msg)
`define RFA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

FILE: hw/rtl/rfa_pkg.sv
package rfa_pkg;

  localparam int FRAC_BITS       = 12;
  localparam int COS_TABLE_DEPTH = 256;

  localparam int COORD_W = 16;
  localparam int OBJ_W   = 27;
  localparam logic [OBJ_W-1:0] OBJ_MAX = '1;

  // phase index: j selects within a quarter, two more bits pick the quarter
  localparam int J_W = $clog2(COS_TABLE_DEPTH);
  localparam int P_W = J_W + 2;

  localparam int SQ_W   = 2 * COORD_W - FRAC_BITS;
  localparam int COS10_W = FRAC_BITS + 5;
  localparam int TERM_W = ((SQ_W > COS10_W) ? SQ_W : COS10_W) + 1;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'd1073741824;

  typedef logic [FRAC_BITS:0] cos_entry_t;
  typedef cos_entry_t cos_rom_t [COS_TABLE_DEPTH+1];

  // cos(pi/2 * i / depth) in q.FRAC_BITS from an 11-term taylor series in q30
  function automatic cos_entry_t cos_quarter(int unsigned i);
    logic [63:0] t;
    logic [63:0] t2;
    logic [63:0] trm;
    logic signed [63:0] acc;
    logic [63:0] rnd;
    if (i >= COS_TABLE_DEPTH) begin
      return '0;
    end
    t   = (64'(i) * HALF_PI_Q30) / COS_TABLE_DEPTH;
    t2  = (t * t) >> 30;
    trm = ONE_Q30;
    acc = $signed(ONE_Q30);
    trm = ((trm * t2) >> 30) / 2;   acc = acc - $signed(trm);
    trm = ((trm * t2) >> 30) / 12;  acc = acc + $signed(trm);
    trm = ((trm * t2) >> 30) / 30;  acc = acc - $signed(trm);
    trm = ((trm * t2) >> 30) / 56;  acc = acc + $signed(trm);
    trm = ((trm * t2) >> 30) / 90;  acc = acc - $signed(trm);
    trm = ((trm * t2) >> 30) / 132; acc = acc + $signed(trm);
    trm = ((trm * t2) >> 30) / 182; acc = acc - $signed(trm);
    trm = ((trm * t2) >> 30) / 240; acc = acc + $signed(trm);
    trm = ((trm * t2) >> 30) / 306; acc = acc - $signed(trm);
    trm = ((trm * t2) >> 30) / 380; acc = acc + $signed(trm);
    if (acc < 0) begin
      acc = 0;
    end
    if (acc > $signed(ONE_Q30)) begin
      acc = $signed(ONE_Q30);
    end
    rnd = ($unsigned(acc) + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
    return rnd[FRAC_BITS:0];
  endfunction

  function automatic cos_rom_t build_cos_rom();
    cos_rom_t r;
    for (int i = 0; i <= COS_TABLE_DEPTH; i++) begin
      r[i] = cos_quarter(i);
    end
    return r;
  endfunction

  localparam cos_rom_t COS_ROM = build_cos_rom();

endpackage

FILE: hw/rtl/rfa_if.sv
interface rfa_in_if import rfa_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] coord;
  logic                      last_coord;

  modport source (output valid, output coord, output last_coord, input ready);
  modport sink   (input valid, input coord, input last_coord, output ready);
endinterface

interface rfa_out_if import rfa_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OBJ_W-1:0] objective;
  logic             overflowed;

  modport source (output valid, output objective, output overflowed, input ready);
  modport sink   (input valid, input objective, input overflowed, output ready);
endinterface

FILE: hw/rtl/rastrigin_fitness_accumulator_core.sv
// path: a coordinate is held in the input register; a last one's result then goes to the output register
// throughput: one coordinate per cycle while ready is high, set by the combinational term and accumulate path
// ready drops only while a last coordinate waits behind an untaken result
// reset (synchronous, active high) clears the running sum, the saturation flag
// and both valid bits; the cosine table is a constant and needs no fill
`include "rastrigin_fitness_accumulator_core_macros.svh"

module rastrigin_fitness_accumulator_core import rfa_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  rfa_in_if.sink    item,
  rfa_out_if.source result
);

  // input register
  logic                      s1_valid;
  logic signed [COORD_W-1:0] s1_coord;
  logic                      s1_last;

  // accumulator and output register
  logic [OBJ_W-1:0] running_sum;
  logic             sat_flag;
  logic             out_valid;
  logic [OBJ_W-1:0] out_objective;
  logic             out_overflowed;

  logic advance;

  logic [COORD_W-1:0]           mag;
  logic [2*COORD_W-1:0]         sq_prod;
  logic [2*COORD_W-1:0]         sq_round;
  logic [SQ_W-1:0]              sq;
  logic [FRAC_BITS-1:0]         frac;
  logic [FRAC_BITS+P_W-1:0]     phase_prod;
  logic [P_W-1:0]               p;
  logic [1:0]                   q;
  logic [J_W-1:0]               j;
  logic [J_W:0]                 rom_idx;
  cos_entry_t                   cos_mag;
  logic                         cos_neg;
  logic [COS10_W-1:0]           cos10;
  logic [TERM_W:0]              pos_part;
  logic [TERM_W:0]              neg_part;
  logic [TERM_W:0]              diff;
  logic [TERM_W-1:0]            term;
  logic [OBJ_W:0]               sum_wide;
  logic [OBJ_W-1:0]             sum_next;
  logic                         sat_next;

  assign advance    = s1_valid && (!s1_last || !out_valid || result.ready);
  assign item.ready = !s1_valid || advance;

  // square of |x|, rounded half up to FRAC_BITS fraction bits
  always_comb begin
    mag      = s1_coord[COORD_W-1] ? (~s1_coord + 1'b1) : s1_coord;
    sq_prod  = (2*COORD_W)'(mag) * (2*COORD_W)'(mag);
    sq_round = sq_prod + ((2*COORD_W)'(1) << (FRAC_BITS - 1));
    sq       = sq_round[2*COORD_W-1:FRAC_BITS];
  end

  // period is one, so the phase is just the fraction bits
  always_comb begin
    frac       = s1_coord[FRAC_BITS-1:0];
    phase_prod = (FRAC_BITS+P_W)'(frac) * (FRAC_BITS+P_W)'(4 * COS_TABLE_DEPTH);
    p          = phase_prod[FRAC_BITS+P_W-1:FRAC_BITS];
    q          = p[P_W-1:J_W];
    j          = p[J_W-1:0];
    rom_idx    = q[0] ? ((J_W+1)'(COS_TABLE_DEPTH) - {1'b0, j}) : {1'b0, j};
    cos_mag    = COS_ROM[rom_idx];
    cos_neg    = q[0] ^ q[1];
    cos10      = (COS10_W'(cos_mag) << 3) + (COS10_W'(cos_mag) << 1);
  end

  // term = sq + 10 - 10*cos, then saturating accumulate
  always_comb begin
    pos_part = (TERM_W+1)'(sq) + (TERM_W+1)'(10 << FRAC_BITS)
             + (cos_neg ? (TERM_W+1)'(cos10) : '0);
    neg_part = cos_neg ? '0 : (TERM_W+1)'(cos10);
    diff     = pos_part - neg_part;
    term     = diff[TERM_W] ? '0 : diff[TERM_W-1:0];
    sum_wide = {1'b0, running_sum} + (OBJ_W+1)'(term);
    sum_next = sum_wide[OBJ_W] ? OBJ_MAX : sum_wide[OBJ_W-1:0];
    sat_next = sat_flag | sum_wide[OBJ_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item.ready) begin
      s1_valid <= item.valid;
    end
    if (item.valid && item.ready) begin
      s1_coord <= item.coord;
      s1_last  <= item.last_coord;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= '0;
      sat_flag    <= 1'b0;
    end else if (advance) begin
      if (s1_last) begin
        running_sum <= '0;
        sat_flag    <= 1'b0;
      end else begin
        running_sum <= sum_next;
        sat_flag    <= sat_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && s1_last) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
    if (advance && s1_last) begin
      out_objective  <= sum_next;
      out_overflowed <= sat_next;
    end
  end

  assign result.valid      = out_valid;
  assign result.objective  = out_objective;
  assign result.overflowed = out_overflowed;

  `RFA_ASSERT_NEXT(a_clear_after_last, advance && s1_last, running_sum == '0 && !sat_flag, "sum not cleared after last beat")
  `RFA_ASSERT_NEXT(a_result_follows_last, advance && s1_last, result.valid, "no result after last beat")
  `RFA_ASSERT_IMPLIES(a_stall_cause, !item.ready, s1_valid && s1_last && out_valid && !result.ready, "input stalled without cause")
  `RFA_ASSERT_IMPLIES(a_sat_pins_max, result.valid && result.overflowed, result.objective == OBJ_MAX, "overflowed result below maximum")

endmodule

FILE: bench/rastrigin_fitness_accumulator_core_test.sv
`timescale 1ns / 1ps

module rastrigin_fitness_accumulator_core_test import rfa_pkg::*; ();

  localparam int CYCLE_LIMIT  = 400000;
  localparam int LONG_HOLD    = 300;
  localparam int TOTAL_COORDS = 1600;
  localparam int SAT_VEC_LEN  = 560;
  localparam longint unsigned SUM_CAP = (64'd1 << OBJ_W) - 1;

  typedef struct {
    logic [OBJ_W-1:0] objective;
    logic             overflowed;
  } fitness_t;

  class fitness_scoreboard;
    int unsigned      cos_q [COS_TABLE_DEPTH+1];
    longint unsigned  run_sum;
    logic             sat;
    fitness_t         pending_q [$];
    int unsigned      mismatches;
    int unsigned      coords_seen;
    int unsigned      results_seen;
    int unsigned      saturated_seen;

    function new();
      for (int i = 0; i <= COS_TABLE_DEPTH; i++) begin
        cos_q[i] = quarter_cos(i);
      end
      run_sum = 0;
      sat = 1'b0;
      mismatches = 0;
      coords_seen = 0;
      results_seen = 0;
      saturated_seen = 0;
    endfunction

    // taylor series in q30, then rounded half up to FRAC_BITS fraction bits
    function int unsigned quarter_cos(int unsigned i);
      longint unsigned ang;
      longint unsigned ang2;
      longint unsigned part;
      longint signed   acc_q30;
      if (i >= COS_TABLE_DEPTH) begin
        return 0;
      end
      ang = (longint'(i) * HALF_PI_Q30) / COS_TABLE_DEPTH;
      ang2 = (ang * ang) >> 30;
      part = 64'd1 << 30;
      acc_q30 = 64'sd1 << 30;
      for (int k = 1; k <= 10; k++) begin
        part = ((part * ang2) >> 30) / longint'((2 * k - 1) * (2 * k));
        if (k % 2 == 1) begin
          acc_q30 = acc_q30 - longint'(part);
        end else begin
          acc_q30 = acc_q30 + longint'(part);
        end
      end
      if (acc_q30 < 0) begin
        acc_q30 = 0;
      end
      if (acc_q30 > (64'sd1 << 30)) begin
        acc_q30 = 64'sd1 << 30;
      end
      return int'((acc_q30 + (64'sd1 << (29 - FRAC_BITS))) >>> (30 - FRAC_BITS));
    endfunction

    // period is one, so only the fraction bits pick the phase
    function longint signed cos_of(logic [FRAC_BITS-1:0] frac);
      int unsigned f;
      int unsigned p;
      int unsigned q;
      int unsigned j;
      f = frac;
      p = (f * 4 * COS_TABLE_DEPTH) >> FRAC_BITS;
      q = (p / COS_TABLE_DEPTH) % 4;
      j = p % COS_TABLE_DEPTH;
      case (q)
        0: return longint'(cos_q[j]);
        1: return -longint'(cos_q[COS_TABLE_DEPTH - j]);
        2: return -longint'(cos_q[j]);
        default: return longint'(cos_q[COS_TABLE_DEPTH - j]);
      endcase
    endfunction

    function void note_coord(logic signed [COORD_W-1:0] c, logic lastc);
      longint signed   xs;
      longint unsigned mag;
      longint unsigned sq;
      longint signed   trm;
      longint unsigned total;
      fitness_t        e;
      xs = c;
      mag = (xs < 0) ? longint'(-xs) : longint'(xs);
      sq = (mag * mag + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
      trm = longint'(sq) + (64'sd10 << FRAC_BITS) - 10 * cos_of(c[FRAC_BITS-1:0]);
      if (trm < 0) begin
        trm = 0;
      end
      total = run_sum + longint'(trm);
      if (total > SUM_CAP) begin
        total = SUM_CAP;
        sat = 1'b1;
      end
      run_sum = total;
      coords_seen++;
      if (lastc) begin
        e.objective = run_sum[OBJ_W-1:0];
        e.overflowed = sat;
        pending_q.push_back(e);
        run_sum = 0;
        sat = 1'b0;
      end
    endfunction

    function void check_result(logic [OBJ_W-1:0] obj, logic ovf);
      fitness_t e;
      if (pending_q.size() == 0) begin
        $error("result beat with no vector pending: objective %0d overflowed %0b", obj, ovf);
        mismatches++;
        return;
      end
      e = pending_q.pop_front();
      results_seen++;
      if (e.overflowed) begin
        saturated_seen++;
      end
      if (obj !== e.objective) begin
        $error("objective: expected %0d, actual %0d", e.objective, obj);
        mismatches++;
      end
      if (ovf !== e.overflowed) begin
        $error("overflowed: expected %0b, actual %0b", e.overflowed, ovf);
        mismatches++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic quiet = 1'b0;
  logic hold_request = 1'b0;
  int unsigned cycle_count = 0;
  int unsigned sent = 0;
  fitness_scoreboard board;

  rfa_in_if  item_if ();
  rfa_out_if result_if ();

  rastrigin_fitness_accumulator_core u_top (
    .clk    (clk),
    .rst    (rst),
    .item   (item_if),
    .result (result_if)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one, none in quiet stretches
  function automatic int pick_gap();
    int unsigned r;
    if (quiet) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end
    if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [COORD_W-1:0] rand_coord();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 50) begin
      return COORD_W'($urandom_range(0, 65535));
    end
    if (sel < 70) begin
      // within one unit of zero
      return COORD_W'($urandom_range(0, 8191) - 4096);
    end
    if (sel < 85) begin
      case ($urandom_range(0, 5))
        0: return 16'h7FFF;
        1: return 16'h8000;
        2: return 16'h0000;
        3: return 16'hFFFF;
        4: return {4'($urandom_range(0, 15)), 12'h000};
        default: return {4'($urandom_range(0, 15)), 12'h800};
      endcase
    end
    // quarter points, nudged by one lsb either way
    return {4'($urandom_range(0, 15)), 2'($urandom_range(0, 3)), 10'h000}
           + COORD_W'($urandom_range(0, 2) - 1);
  endfunction

  function automatic int pick_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      return $urandom_range(1, 4);
    end
    if (r < 95) begin
      return $urandom_range(5, 12);
    end
    return $urandom_range(13, 40);
  endfunction

  task automatic send_coord(input logic signed [COORD_W-1:0] c, input logic lastc);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      item_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_if.valid <= 1'b1;
    item_if.coord <= c;
    item_if.last_coord <= lastc;
    do @(posedge clk); while (!item_if.ready);
    board.note_coord(c, lastc);
    sent++;
  endtask

  task automatic wait_drained();
    while (board.pending_q.size() != 0) @(posedge clk);
  endtask

  // result side: random stalls, plus one long hold on request
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    result_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_if.valid && result_if.ready) begin
        board.check_result(result_if.objective, result_if.overflowed);
      end
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left = LONG_HOLD;
      end else if (stall_left == 0) begin
        stall_left = pick_gap();
      end
      if (stall_left > 0) begin
        stall_left--;
        result_if.ready <= 1'b0;
      end else begin
        result_if.ready <= 1'b1;
      end
    end
  end

  initial begin : coord_source
    logic signed [COORD_W-1:0] singles [12];
    logic signed [COORD_W-1:0] multi [8];
    int len;
    logic held;
    logic drained;
    board = new();
    item_if.valid = 1'b0;
    item_if.coord = '0;
    item_if.last_coord = 1'b0;
    held = 1'b0;
    drained = 1'b0;
    // zero, range ends, +-1 lsb, phase quarter points, whole and half units
    singles = '{16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h0001, 16'h0800,
                16'h0400, 16'h0C00, 16'h0FFF, 16'hF800, 16'h1000, 16'h8800};
    multi = '{16'h2000, 16'hE000, 16'h0A3D, 16'h5555, 16'hAAAA,
              16'h7FFF, 16'h8000, 16'h7FFF};
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (singles[i]) begin
      send_coord(singles[i], 1'b1);
    end
    for (int i = 0; i < 8; i++) begin
      send_coord(multi[i], (i == 4) || (i == 7));
    end

    // long vector of coordinates near -8 that must saturate the sum
    for (int i = 0; i < SAT_VEC_LEN; i++) begin
      send_coord({6'b100000, 10'($urandom)}, i == SAT_VEC_LEN - 1);
    end

    while (sent < TOTAL_COORDS) begin
      if ($urandom_range(0, 7) == 0) begin
        quiet = ~quiet;
      end
      if (!held && sent >= 800) begin
        // receiver holds off while whole vectors keep coming
        held = 1'b1;
        quiet = 1'b0;
        hold_request = 1'b1;
      end
      if (!drained && sent >= 1200) begin
        drained = 1'b1;
        item_if.valid <= 1'b0;
        wait_drained();
      end
      len = pick_len();
      for (int i = 0; i < len; i++) begin
        send_coord(rand_coord(), i == len - 1);
      end
    end
    item_if.valid <= 1'b0;

    wait_drained();
    repeat (6) @(posedge clk);
    $display("run covered %0d coordinates in %0d vectors, %0d of them saturated",
             board.coords_seen, board.results_seen, board.saturated_seen);
    $display("phase extremes, a long saturating vector, a long output hold and a drain pause");
    if (board.mismatches == 0 && board.pending_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
